### rtl/tes_pkg.sv
// Shared types and constants for the text encoding sniffer.
package tes_pkg;

    // Result encodings, in the order used on the result channel.
    typedef enum logic [2:0] {
        ENC_UNKNOWN = 3'd0,
        ENC_ANSI    = 3'd1,
        ENC_UTF8    = 3'd2,
        ENC_UTF16LE = 3'd3,
        ENC_UTF16BE = 3'd4,
        ENC_UTF32LE = 3'd5,
        ENC_UTF32BE = 3'd6
    } encoding_t;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned HEAD_W   = 32;
    localparam int unsigned COUNT_W  = 3;
    localparam int unsigned PEND_W   = 2;
    localparam int unsigned HDRLEN_W = 3;

    // Byte order marks, first byte in the lowest lane.
    localparam logic [31:0] BOM_UTF32LE = 32'h0000_FEFF;
    localparam logic [31:0] BOM_UTF32BE = 32'hFFFE_0000;
    localparam logic [23:0] BOM_UTF8    = 24'hBF_BBEF;
    localparam logic [15:0] BOM_UTF16BE = 16'hFFFE;
    localparam logic [15:0] BOM_UTF16LE = 16'hFEFF;

    // Lead and continuation byte patterns.
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_CODE  = 8'h80;
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_CODE = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_CODE = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_CODE = 8'hF0;

    // Mark lengths in bytes.
    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN_2    = 3'd2;
    localparam logic [2:0] LEN_3    = 3'd3;
    localparam logic [2:0] LEN_4    = 3'd4;

endpackage

### rtl/tes_if.sv
// Channel interfaces for document bytes and classification results.
interface tes_byte_if;
    logic                         valid;
    logic                         ready;
    logic [tes_pkg::BYTE_W-1:0]   data_byte;
    logic                         last_byte;
    logic                         empty_document;

    modport source (output valid, data_byte, last_byte, empty_document, input ready);
    modport sink   (input valid, data_byte, last_byte, empty_document, output ready);
endinterface

interface tes_result_if;
    logic                          valid;
    logic                          ready;
    tes_pkg::encoding_t            encoding;
    logic [tes_pkg::HDRLEN_W-1:0]  header_length;

    modport source (output valid, encoding, header_length, input ready);
    modport sink   (input valid, encoding, header_length, output ready);
endinterface

### rtl/text_encoding_sniffer.sv
// Top level of the text encoding sniffer: mark matching and UTF-8 structure check.
//
//   channel   direction  transaction
//   doc       in         one document byte, last marker, empty-document marker
//   result    out        encoding and byte order mark length, one per document
//
// Each byte is captured in an input register and classified in the next cycle,
// where the running state (first four bytes, count, owed continuations, error
// flag) is updated; one byte per cycle is sustained except during a stall.
// The result register is loaded as the final byte leaves the input register. Reset
// clears the valid flags and document state. A result waiting at the output holds
// the next document-ending byte in the input register; input stalls until taken.
module text_encoding_sniffer (
    input  logic             clk,
    input  logic             rst_n,
    tes_byte_if.sink         doc,
    tes_result_if.source     result
);

    // Input register
    logic                            s1_valid_reg;
    logic [tes_pkg::BYTE_W-1:0]      s1_byte_reg;
    logic                            s1_last_reg;
    logic                            s1_empty_reg;

    // Document state
    logic [tes_pkg::HEAD_W-1:0]      head_reg;
    logic [tes_pkg::HEAD_W-1:0]      head_next;
    logic [tes_pkg::COUNT_W-1:0]     count_reg;
    logic [tes_pkg::COUNT_W-1:0]     count_next;
    logic [tes_pkg::PEND_W-1:0]      pend_reg;
    logic [tes_pkg::PEND_W-1:0]      pend_next;
    logic                            invalid_reg;
    logic                            invalid_next;

    // Result register
    logic                            out_valid_reg;
    tes_pkg::encoding_t              out_enc_reg;
    logic [tes_pkg::HDRLEN_W-1:0]    out_len_reg;

    logic                            s1_has_result;
    logic                            s1_advance;
    tes_pkg::encoding_t              enc_next;
    logic [tes_pkg::HDRLEN_W-1:0]    len_next;

    // Handshake: the input stage moves on unless it holds a result that cannot leave.
    assign s1_has_result = s1_valid_reg && (s1_last_reg || s1_empty_reg);
    assign s1_advance    = s1_valid_reg && (!s1_has_result || !out_valid_reg || result.ready);
    assign doc.ready     = !s1_valid_reg || s1_advance;

    assign result.valid         = out_valid_reg;
    assign result.encoding      = out_enc_reg;
    assign result.header_length = out_len_reg;

    // Capture of the first four bytes, saturating the count at four.
    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        case (count_reg)
            3'd0:
            begin
                head_next[7:0] = s1_byte_reg;
                count_next     = 3'd1;
            end
            3'd1:
            begin
                head_next[15:8] = s1_byte_reg;
                count_next      = 3'd2;
            end
            3'd2:
            begin
                head_next[23:16] = s1_byte_reg;
                count_next       = 3'd3;
            end
            3'd3:
            begin
                head_next[31:24] = s1_byte_reg;
                count_next       = 3'd4;
            end
            default:
            begin
                head_next  = head_reg;
                count_next = count_reg;
            end
        endcase
    end

    // UTF-8 lead and continuation check.
    always_comb
    begin
        pend_next    = pend_reg;
        invalid_next = invalid_reg;
        if (pend_reg != '0)
        begin
            if ((s1_byte_reg & tes_pkg::CONT_MASK) == tes_pkg::CONT_CODE)
            begin
                pend_next = pend_reg - 2'd1;
            end
            else
            begin
                invalid_next = 1'b1;
            end
        end
        else if (s1_byte_reg[7])
        begin
            if ((s1_byte_reg & tes_pkg::LEAD2_MASK) == tes_pkg::LEAD2_CODE)
            begin
                pend_next = 2'd1;
            end
            else if ((s1_byte_reg & tes_pkg::LEAD3_MASK) == tes_pkg::LEAD3_CODE)
            begin
                pend_next = 2'd2;
            end
            else if ((s1_byte_reg & tes_pkg::LEAD4_MASK) == tes_pkg::LEAD4_CODE)
            begin
                pend_next = 2'd3;
            end
            else
            begin
                invalid_next = 1'b1;
            end
        end
    end

    // Classification at the end of a document, longest mark first.
    always_comb
    begin
        len_next = tes_pkg::LEN_NONE;
        if (s1_empty_reg)
        begin
            enc_next = tes_pkg::ENC_UNKNOWN;
        end
        else if (count_next >= 3'd4 && head_next == tes_pkg::BOM_UTF32LE)
        begin
            enc_next = tes_pkg::ENC_UTF32LE;
            len_next = tes_pkg::LEN_4;
        end
        else if (count_next >= 3'd4 && head_next == tes_pkg::BOM_UTF32BE)
        begin
            enc_next = tes_pkg::ENC_UTF32BE;
            len_next = tes_pkg::LEN_4;
        end
        else if (count_next >= 3'd3 && head_next[23:0] == tes_pkg::BOM_UTF8)
        begin
            enc_next = tes_pkg::ENC_UTF8;
            len_next = tes_pkg::LEN_3;
        end
        else if (count_next >= 3'd2 && head_next[15:0] == tes_pkg::BOM_UTF16BE)
        begin
            enc_next = tes_pkg::ENC_UTF16BE;
            len_next = tes_pkg::LEN_2;
        end
        else if (count_next >= 3'd2 && head_next[15:0] == tes_pkg::BOM_UTF16LE)
        begin
            enc_next = tes_pkg::ENC_UTF16LE;
            len_next = tes_pkg::LEN_2;
        end
        else if (!invalid_next && pend_next == '0)
        begin
            enc_next = tes_pkg::ENC_UTF8;
        end
        else
        begin
            enc_next = tes_pkg::ENC_ANSI;
        end
    end

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (doc.ready)
        begin
            s1_valid_reg <= doc.valid;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (doc.valid && doc.ready)
        begin
            s1_byte_reg  <= doc.data_byte;
            s1_last_reg  <= doc.last_byte;
            s1_empty_reg <= doc.empty_document;
        end
    end

    // Document state, cleared after every result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            count_reg   <= '0;
            pend_reg    <= '0;
            invalid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            if (s1_has_result)
            begin
                head_reg    <= '0;
                count_reg   <= '0;
                pend_reg    <= '0;
                invalid_reg <= 1'b0;
            end
            else
            begin
                head_reg    <= head_next;
                count_reg   <= count_next;
                pend_reg    <= pend_next;
                invalid_reg <= invalid_next;
            end
        end
    end

    // Result register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance && s1_has_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_has_result)
        begin
            out_enc_reg <= enc_next;
            out_len_reg <= len_next;
        end
    end

endmodule
